### hdl/fcr_pkg.sv
// Shared types and constants for the framed command receiver.
// Used by fcr_parser, fcr_cfg_regs and framed_command_receiver; no dependencies.

package fcr_pkg;

    localparam logic [7:0] SOF_BYTE  = 8'hAA;
    localparam logic [7:0] EOF_BYTE  = 8'h55;
    localparam logic [7:0] FRAME_LEN = 8'd8;

    localparam int unsigned REG_W_CODE    = 32;
    localparam int unsigned REG_W_TIMEOUT = 16;

    // Configuration register indexes (byte address / 4).
    localparam logic REG_MAX_CODE      = 1'b0;
    localparam logic REG_TIMEOUT_TICKS = 1'b1;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_LEN  = 3'd1,
        PH_DATA = 3'd2,
        PH_CHK  = 3'd3,
        PH_END  = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_TIMEOUT  = 3'd1,
        ST_BAD_LEN  = 3'd2,
        ST_BAD_END  = 3'd3,
        ST_BAD_CSUM = 3'd4,
        ST_BAD_CODE = 3'd5
    } status_t;

    typedef struct packed {
        logic [31:0] argument_bits;
        logic [31:0] command_code;
        status_t     status;
    } result_t;

    typedef struct packed {
        logic [REG_W_TIMEOUT-1:0] timeout_ticks;
        logic [REG_W_CODE-1:0]    max_code;
    } cfg_t;

endpackage

### hdl/framed_command_receiver.sv
// Top level of the framed command receiver: configuration port, parser and
// result register. Depends on fcr_pkg, fcr_cfg_regs and fcr_parser.

// One input transfer (a received byte or a time tick) is taken in every clock
// cycle while s_tready is high; each transfer is fully processed in the cycle
// it is accepted and any result it causes is presented on the m_ channel from
// the next cycle. The single result register sets the rate: s_tready is low
// only while a result is held and m_tready is low, so with m_tready high the
// block sustains one transfer per cycle. Frames are 0xAA, length 8, eight
// payload bytes, an XOR checksum and 0x55; one result follows each completed
// frame, each framing error and each timeout inside a frame.

module framed_command_receiver (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] operation (0 byte, 1 tick)
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [2:0] status, [34:3] command_code,
                                   // [66:35] argument_bits, [71:67] zero
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    fcr_pkg::cfg_t    cfg;
    fcr_pkg::result_t res;
    fcr_pkg::result_t res_reg;
    logic             res_valid;
    logic             m_tvalid_reg;
    logic             in_accept;

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    fcr_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fcr_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .operation (s_tuser),
        .rx_byte   (s_tdata),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_tready) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, res_reg.argument_bits, res_reg.command_code,
                       res_reg.status};

endmodule

### hdl/fcr_cfg_regs.sv
// APB-style configuration registers of the framed command receiver.
// Depends on fcr_pkg for the register indexes and the cfg_t bundle.

module fcr_cfg_regs (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output fcr_pkg::cfg_t     cfg
);

    logic [31:0] max_code_reg;
    logic [15:0] timeout_ticks_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_code_reg      <= 32'd15;
            timeout_ticks_reg <= 16'd1000;
        end else if (wr_en) begin
            case (paddr[2])
                fcr_pkg::REG_MAX_CODE:      max_code_reg      <= pwdata;
                fcr_pkg::REG_TIMEOUT_TICKS: timeout_ticks_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            fcr_pkg::REG_MAX_CODE:      prdata = max_code_reg;
            fcr_pkg::REG_TIMEOUT_TICKS: prdata = {16'd0, timeout_ticks_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    assign cfg.max_code      = max_code_reg;
    assign cfg.timeout_ticks = timeout_ticks_reg;

endmodule

### hdl/fcr_parser.sv
// Frame parsing state machine: start, length, payload with running XOR,
// checksum and end byte, plus the idle tick counter. Depends on fcr_pkg.

module fcr_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_accept,
    input  logic              operation,
    input  logic [7:0]        rx_byte,
    input  fcr_pkg::cfg_t     cfg,
    output logic              res_valid,
    output fcr_pkg::result_t  res
);

    fcr_pkg::phase_t phase_reg, phase_next;
    logic [2:0]      index_reg, index_next;
    logic [7:0][7:0] payload_reg, payload_next;
    logic [7:0]      xor_reg, xor_next;
    logic [7:0]      csum_reg, csum_next;
    logic [15:0]     idle_reg, idle_next;

    logic [15:0] idle_inc;
    logic        timeout_hit;
    logic [31:0] code;
    logic [31:0] arg;

    assign idle_inc    = (idle_reg == 16'hFFFF) ? idle_reg : idle_reg + 16'd1;
    assign timeout_hit = idle_inc >= cfg.timeout_ticks;
    assign code        = payload_reg[3:0];
    assign arg         = payload_reg[7:4];

    // Next phase.
    always_comb begin
        phase_next = phase_reg;
        if (in_accept) begin
            if (operation == fcr_pkg::OP_TICK) begin
                if (phase_reg != fcr_pkg::PH_HUNT && timeout_hit) begin
                    phase_next = fcr_pkg::PH_HUNT;
                end
            end else begin
                case (phase_reg)
                    fcr_pkg::PH_HUNT: begin
                        if (rx_byte == fcr_pkg::SOF_BYTE) begin
                            phase_next = fcr_pkg::PH_LEN;
                        end
                    end
                    fcr_pkg::PH_LEN: begin
                        phase_next = (rx_byte == fcr_pkg::FRAME_LEN) ? fcr_pkg::PH_DATA
                                                                     : fcr_pkg::PH_HUNT;
                    end
                    fcr_pkg::PH_DATA: begin
                        if (index_reg == 3'd7) begin
                            phase_next = fcr_pkg::PH_CHK;
                        end
                    end
                    fcr_pkg::PH_CHK: phase_next = fcr_pkg::PH_END;
                    fcr_pkg::PH_END: phase_next = fcr_pkg::PH_HUNT;
                    default:         phase_next = fcr_pkg::PH_HUNT;
                endcase
            end
        end
    end

    // Datapath updates and the result.
    always_comb begin
        index_next         = index_reg;
        payload_next       = payload_reg;
        xor_next           = xor_reg;
        csum_next          = csum_reg;
        idle_next          = idle_reg;
        res_valid          = 1'b0;
        res.status         = fcr_pkg::ST_OK;
        res.command_code   = 32'd0;
        res.argument_bits  = 32'd0;
        if (in_accept) begin
            if (operation == fcr_pkg::OP_TICK) begin
                if (phase_reg == fcr_pkg::PH_HUNT) begin
                    idle_next = 16'd0;
                end else if (timeout_hit) begin
                    idle_next  = 16'd0;
                    index_next = 3'd0;
                    res_valid  = 1'b1;
                    res.status = fcr_pkg::ST_TIMEOUT;
                end else begin
                    idle_next = idle_inc;
                end
            end else begin
                idle_next = 16'd0;
                case (phase_reg)
                    fcr_pkg::PH_LEN: begin
                        if (rx_byte != fcr_pkg::FRAME_LEN) begin
                            res_valid  = 1'b1;
                            res.status = fcr_pkg::ST_BAD_LEN;
                        end else begin
                            index_next = 3'd0;
                            xor_next   = 8'd0;
                        end
                    end
                    fcr_pkg::PH_DATA: begin
                        payload_next[index_reg] = rx_byte;
                        xor_next                = xor_reg ^ rx_byte;
                        index_next              = index_reg + 3'd1;
                    end
                    fcr_pkg::PH_CHK: csum_next = rx_byte;
                    fcr_pkg::PH_END: begin
                        res_valid = 1'b1;
                        if (rx_byte != fcr_pkg::EOF_BYTE) begin
                            res.status = fcr_pkg::ST_BAD_END;
                        end else if (csum_reg != xor_reg) begin
                            res.status = fcr_pkg::ST_BAD_CSUM;
                        end else if (code > cfg.max_code) begin
                            res.status        = fcr_pkg::ST_BAD_CODE;
                            res.command_code  = cfg.max_code;
                            res.argument_bits = arg;
                        end else begin
                            res.status        = fcr_pkg::ST_OK;
                            res.command_code  = code;
                            res.argument_bits = arg;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= fcr_pkg::PH_HUNT;
            index_reg <= 3'd0;
            xor_reg   <= 8'd0;
            csum_reg  <= 8'd0;
            idle_reg  <= 16'd0;
        end else begin
            phase_reg <= phase_next;
            index_reg <= index_next;
            xor_reg   <= xor_next;
            csum_reg  <= csum_next;
            idle_reg  <= idle_next;
        end
    end

    always_ff @(posedge aclk) begin
        payload_reg <= payload_next;
    end

    // Every reported result ends the frame.
    a_result_ends_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |=> phase_reg == fcr_pkg::PH_HUNT)
        else $error("parser not hunting after a result");

    // Ticks while hunting never produce a timeout.
    a_no_timeout_hunting: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && operation == fcr_pkg::OP_TICK && phase_reg == fcr_pkg::PH_HUNT
        |-> !res_valid)
        else $error("timeout reported while hunting");

    // A received byte restarts the idle count.
    a_byte_clears_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && operation == fcr_pkg::OP_BYTE |=> idle_reg == 16'd0)
        else $error("idle count not cleared by a byte");

    // The payload index only moves off zero while collecting payload.
    a_index_in_data: assert property (@(posedge aclk) disable iff (!aresetn)
        index_reg != 3'd0 |-> phase_reg == fcr_pkg::PH_DATA)
        else $error("payload index stale outside payload phase");

endmodule

### verif/fcr_scoreboard_pkg.sv
// Scoreboard for the framed command receiver testbench: a frame predictor and
// the queue of results it expects. Depends on fcr_pkg for the result and phase types.

package fcr_scoreboard_pkg;

    import fcr_pkg::*;

    class fcr_scoreboard;

        // Register copies and the predicted state of the frame parser.
        logic [31:0] code_limit;
        logic [15:0] tick_limit;
        phase_t      frame_phase;
        logic [2:0]  byte_pos;
        logic [63:0] payload;
        logic [7:0]  xor_acc;
        logic [7:0]  sent_checksum;
        logic [15:0] idle_count;

        result_t     expected_q[$];
        int          errors;
        int          transfers;
        int          tally[8];

        function new();
            code_limit    = 32'd15;
            tick_limit    = 16'd1000;
            frame_phase   = PH_HUNT;
            byte_pos      = '0;
            payload       = '0;
            xor_acc       = '0;
            sent_checksum = '0;
            idle_count    = '0;
            errors        = 0;
            transfers     = 0;
            foreach (tally[k]) tally[k] = 0;
        endfunction

        function void set_register(logic idx, logic [31:0] value);
            if (idx == REG_MAX_CODE) code_limit = value;
            else tick_limit = value[15:0];
        endfunction

        function logic [31:0] register_value(logic idx);
            if (idx == REG_MAX_CODE) return code_limit;
            return {16'd0, tick_limit};
        endfunction

        function void check_register(logic idx, logic [31:0] got);
            if (got !== register_value(idx)) begin
                $error("register %0d: expected 0x%08h, got 0x%08h", idx, register_value(idx), got);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Advances the predicted parser by one accepted input transfer.
        function void note_input(logic op, logic [7:0] value);
            result_t r;
            bit      hit;
            r   = '0;
            hit = 1'b0;
            transfers++;
            if (op == OP_TICK) begin
                if (frame_phase == PH_HUNT) begin
                    idle_count = '0;
                end else begin
                    if (idle_count != 16'hFFFF) idle_count++;
                    if (idle_count >= tick_limit) begin
                        idle_count = '0;
                        r.status   = ST_TIMEOUT;
                        hit        = 1'b1;
                    end
                end
            end else begin
                idle_count = '0;
                case (frame_phase)
                    PH_HUNT: begin
                        if (value == SOF_BYTE) frame_phase = PH_LEN;
                    end
                    PH_LEN: begin
                        if (value != FRAME_LEN) begin
                            r.status = ST_BAD_LEN;
                            hit      = 1'b1;
                        end else begin
                            byte_pos    = '0;
                            payload     = '0;
                            xor_acc     = '0;
                            frame_phase = PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        payload[int'(byte_pos) * 8 +: 8] = value;
                        xor_acc = xor_acc ^ value;
                        if (byte_pos == 3'd7) begin
                            byte_pos    = '0;
                            frame_phase = PH_CHK;
                        end else begin
                            byte_pos++;
                        end
                    end
                    PH_CHK: begin
                        sent_checksum = value;
                        frame_phase   = PH_END;
                    end
                    PH_END: begin
                        // The end byte wins over the checksum, which wins over the code limit.
                        hit = 1'b1;
                        if (value != EOF_BYTE) begin
                            r.status = ST_BAD_END;
                        end else if (sent_checksum != xor_acc) begin
                            r.status = ST_BAD_CSUM;
                        end else if (payload[31:0] > code_limit) begin
                            r.status        = ST_BAD_CODE;
                            r.command_code  = code_limit;
                            r.argument_bits = payload[63:32];
                        end else begin
                            r.status        = ST_OK;
                            r.command_code  = payload[31:0];
                            r.argument_bits = payload[63:32];
                        end
                    end
                    default: frame_phase = PH_HUNT;
                endcase
            end
            if (hit) begin
                frame_phase = PH_HUNT;
                expected_q.push_back(r);
                tally[r.status]++;
            end
        endfunction

        function void check_result(logic [71:0] word);
            result_t got;
            result_t want;
            got = result_t'(word[66:0]);
            if (expected_q.size() == 0) begin
                $error("unexpected result: status %0d, command_code 0x%08h, argument_bits 0x%08h",
                       got.status, got.command_code, got.argument_bits);
                errors++;
            end else begin
                want = expected_q.pop_front();
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    errors++;
                end
                if (got.command_code !== want.command_code) begin
                    $error("command_code: expected 0x%08h, got 0x%08h",
                           want.command_code, got.command_code);
                    errors++;
                end
                if (got.argument_bits !== want.argument_bits) begin
                    $error("argument_bits: expected 0x%08h, got 0x%08h",
                           want.argument_bits, got.argument_bits);
                    errors++;
                end
                if (word[71:67] !== 5'd0) begin
                    $error("padding: expected 0x00, got 0x%02h", word[71:67]);
                    errors++;
                end
            end
        endfunction

    endclass

endpackage

### verif/framed_command_receiver_tb.sv
// Testbench top for the framed command receiver: drives framed byte streams and
// ticks, configures over APB and checks every result. Depends on fcr_pkg and fcr_scoreboard_pkg.

module framed_command_receiver_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import fcr_pkg::*;
    import fcr_scoreboard_pkg::*;

    localparam int CYCLE_LIMIT  = 400_000;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_QUOTA  = 350;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    fcr_scoreboard sb;
    int          cycle_count   = 0;
    int          burst_left    = 0;
    int          settings_used = 1;
    bit          hold_request  = 1'b0;
    logic [31:0] cur_max_code  = 32'd15;
    int          cur_timeout   = 1000;

    framed_command_receiver dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("framed_command_receiver_tb: FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // Result side: randomly chosen stall patterns that change at random, plus one
    // long hold-off on request so that the input side backs up.
    initial begin : ready_pattern
        int mode;
        int span;
        mode = 0;
        span = 0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_request = 1'b0;
            end
            if (span == 0) begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(50, 300);
            end else begin
                span--;
            end
            case (mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= $urandom_range(0, 1);
                2:       m_tready <= (span % 4) != 0;
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Offers one transfer and returns once it was taken; between bursts it also drops s_tvalid for a random pause.
    task automatic push_item(logic op, logic [7:0] value);
        s_tuser  <= op;
        s_tdata  <= value;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(op, value);
        @(negedge aclk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
        end
    endtask

    task automatic push_ticks(int n);
        repeat (n) push_item(OP_TICK, 8'($urandom_range(0, 255)));
    endtask

    // A cut position above zero stops the frame there with enough ticks to time out.
    task automatic send_frame(logic [31:0] code, logic [31:0] arg, bit bad_len,
                              bit bad_csum, bit bad_end, int cut_at);
        logic [7:0]  seq [12];
        logic [63:0] body;
        logic [7:0]  sum;
        body   = {arg, code};
        sum    = '0;
        seq[0] = SOF_BYTE;
        seq[1] = bad_len ? (FRAME_LEN ^ (8'd1 << $urandom_range(0, 7))) : FRAME_LEN;
        for (int k = 0; k < 8; k++) begin
            seq[k + 2] = body[8 * k +: 8];
            sum        = sum ^ seq[k + 2];
        end
        seq[10] = bad_csum ? (sum ^ 8'($urandom_range(1, 255))) : sum;
        seq[11] = bad_end ? (EOF_BYTE ^ 8'($urandom_range(1, 255))) : EOF_BYTE;
        for (int k = 0; k < 12; k++) begin
            if (k > 0 && k == cut_at) begin
                push_ticks((cur_timeout == 0) ? 1 : cur_timeout);
                break;
            end
            // Quiet stretches shorter than the timeout must not end the frame.
            if (k > 0 && cur_timeout > 1 && $urandom_range(0, 7) == 0)
                push_ticks($urandom_range(1, (cur_timeout > 24) ? 24 : cur_timeout - 1));
            push_item(OP_BYTE, seq[k]);
        end
    endtask

    task automatic apb_access(logic idx, bit is_write, logic [31:0] value);
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        got = prdata;
        if (is_write) sb.set_register(idx, value);
        else sb.check_register(idx, got);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic set_registers(logic [31:0] code_limit, logic [15:0] ticks);
        drain();
        apb_access(REG_MAX_CODE, 1'b1, code_limit);
        apb_access(REG_MAX_CODE, 1'b0, '0);
        apb_access(REG_TIMEOUT_TICKS, 1'b1, {16'd0, ticks});
        apb_access(REG_TIMEOUT_TICKS, 1'b0, '0);
        cur_max_code = code_limit;
        cur_timeout  = int'(ticks);
        settings_used++;
    endtask

    function automatic logic [31:0] pick_code();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return $urandom_range(0, cur_max_code);
            2:       return cur_max_code;
            default: return cur_max_code + 32'd1;
        endcase
    endfunction

    task automatic run_random(int quota);
        int  stop_at;
        int  pick;
        bit  bad_len;
        bit  bad_csum;
        bit  bad_end;
        int  cut_at;
        stop_at = sb.transfers + quota;
        while (sb.transfers < stop_at) begin
            pick = $urandom_range(0, 19);
            if (pick < 12) begin
                send_frame(pick_code(), $urandom, 1'b0, 1'b0, 1'b0, 0);
            end else if (pick < 17) begin
                bad_len  = ($urandom_range(0, 3) == 0);
                bad_csum = 1'($urandom_range(0, 1));
                bad_end  = 1'($urandom_range(0, 1));
                cut_at   = 0;
                if (cur_timeout <= 40 && $urandom_range(0, 2) == 0)
                    cut_at = $urandom_range(1, 11);
                if (!bad_len && !bad_end && cut_at == 0) bad_csum = 1'b1;
                send_frame(pick_code(), $urandom, bad_len, bad_csum, bad_end, cut_at);
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    if ($urandom_range(0, 3) == 0) push_item(OP_BYTE, SOF_BYTE);
                    else push_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Registers must come out of reset at their documented values.
        apb_access(REG_MAX_CODE, 1'b0, '0);
        apb_access(REG_TIMEOUT_TICKS, 1'b0, '0);

        // A tick while hunting is ignored; a start byte in the length slot is a
        // bad length and is not taken as a new start, so the following 8 is ignored.
        push_item(OP_TICK, 8'h00);
        push_item(OP_BYTE, SOF_BYTE);
        push_item(OP_BYTE, SOF_BYTE);
        push_item(OP_BYTE, FRAME_LEN);
        send_frame(32'd15, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 0);

        set_registers(32'd0, 16'd2);
        push_item(OP_BYTE, SOF_BYTE);
        push_item(OP_BYTE, FRAME_LEN);
        push_ticks(2);
        // With a zero limit the very first tick inside a frame times out.
        set_registers(32'd0, 16'd0);
        push_item(OP_BYTE, SOF_BYTE);
        push_item(OP_TICK, 8'hFF);

        set_registers(32'd0, 16'd1);
        run_random(PHASE_QUOTA);
        set_registers(32'hFFFF_FFFF, 16'hFFFF);
        hold_request = 1'b1;
        run_random(PHASE_QUOTA);
        set_registers(32'd15, 16'd1000);
        run_random(PHASE_QUOTA);
        set_registers($urandom, 16'($urandom_range(2, 30)));
        run_random(PHASE_QUOTA);
        set_registers($urandom_range(0, 255), 16'd3);
        run_random(PHASE_QUOTA);

        drain();
        repeat (20) @(negedge aclk);
        $display("Run covered %0d input transfers under %0d register settings.",
                 sb.transfers, settings_used);
        $display("Results seen: ok %0d, timeout %0d, bad length %0d, bad end %0d, %s %0d, %s %0d",
                 sb.tally[ST_OK], sb.tally[ST_TIMEOUT], sb.tally[ST_BAD_LEN],
                 sb.tally[ST_BAD_END], "bad checksum", sb.tally[ST_BAD_CSUM],
                 "bad code", sb.tally[ST_BAD_CODE]);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("framed_command_receiver_tb: PASS");
        end else begin
            $display("framed_command_receiver_tb: FAIL");
        end
        $finish;
    end

endmodule

### framed_command_receiver.f
hdl/fcr_pkg.sv
hdl/fcr_cfg_regs.sv
hdl/fcr_parser.sv
hdl/framed_command_receiver.sv
verif/fcr_scoreboard_pkg.sv
verif/framed_command_receiver_tb.sv
